// ===== design/time_sorted_insert_table_core_macros.svh =====
// Assertion macros for the sorted insertion table.
// Taken in by the modules that carry concurrent assertions.
`ifndef TIME_SORTED_INSERT_TABLE_CORE_MACROS_SVH
`define TIME_SORTED_INSERT_TABLE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TSIT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("tsit assertion failed");
`define TSIT_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("tsit assertion failed");
`else
`define TSIT_ASSERT(lbl, clk, rst_n, prop)
`define TSIT_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// ===== design/tsit_pkg.sv =====
// Shared types, codes and constants of the sorted insertion table.
// No dependencies.
package tsit_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned KEY_W           = 34;
  localparam int unsigned ID_W            = 16;
  localparam int unsigned OWNER_W         = 8;
  localparam int unsigned RANK_W          = 4;
  localparam int unsigned APB_ADDR_W      = 3;
  localparam int unsigned APB_DATA_W      = 32;

  localparam logic REG_FIRST_ID = 1'b0;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_READ   = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_READ_OK  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } time_t;

  typedef struct packed {
    mode_e              mode;
    logic [13:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [OWNER_W-1:0] owner_tag;
    logic [RANK_W-1:0]  read_rank;
  } tsit_in_t;

  typedef struct packed {
    status_e            status;
    logic [ID_W-1:0]    entry_id;
    logic [RANK_W-1:0]  rank;
    logic [13:0]        out_year;
    logic [3:0]         out_month;
    logic [4:0]         out_day;
    logic [4:0]         out_hour;
    logic [5:0]         out_minute;
    logic [OWNER_W-1:0] out_owner;
  } tsit_out_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [OWNER_W-1:0] owner;
    logic [ID_W-1:0]    id;
  } entry_t;

  function automatic logic [KEY_W-1:0] pack_key(tsit_in_t d);
    time_t t;
    t.year   = d.year;
    t.month  = d.month;
    t.day    = d.day;
    t.hour   = d.hour;
    t.minute = d.minute;
    return KEY_W'(t);
  endfunction

endpackage

// ===== design/tsit_mem.sv =====
// Entry store of the sorted insertion table: one write port, one
// registered read port. Depends on tsit_pkg.
module tsit_mem import tsit_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic [IDX_W-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem_q [TABLE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/tsit_ctrl.sv =====
// Sequencer of the sorted insertion table: position search, shift walk,
// read-out and result register. Depends on tsit_pkg and the macro header.
`include "time_sorted_insert_table_core_macros.svh"
module tsit_ctrl import tsit_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tsit_in_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tsit_out_t        out_data_o,
  input  logic [ID_W-1:0]  next_id_i,
  output logic             id_adv_o,
  output logic             mem_we_o,
  output logic [IDX_W-1:0] mem_waddr_o,
  output entry_t           mem_wdata_o,
  output logic [IDX_W-1:0] mem_raddr_o,
  input  entry_t           mem_rdata_i
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCAN   = 8'b0000_0010,
    S_CMP    = 8'b0000_0100,
    S_SHRD   = 8'b0000_1000,
    S_SHWR   = 8'b0001_0000,
    S_WRITE  = 8'b0010_0000,
    S_RDWAIT = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   scan_q, scan_d;
  logic [CNT_W-1:0]   ptr_q, ptr_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [OWNER_W-1:0] owner_q, owner_d;
  tsit_out_t          res_q, res_d;
  tsit_out_t          out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic [CNT_W-1:0]   scan_inc;
  logic [CNT_W-1:0]   ptr_dec;
  time_t              rd_time;

  assign scan_inc = scan_q + 1'b1;
  assign ptr_dec  = ptr_q - 1'b1;
  assign rd_time  = time_t'(mem_rdata_i.key);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_d      = scan_q;
    ptr_d       = ptr_q;
    key_d       = key_q;
    owner_d     = owner_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    id_adv_o    = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = IDX_W'(scan_q);
    mem_raddr_o = IDX_W'(scan_q);
    mem_wdata_o = '{key: key_q, owner: owner_q, id: next_id_i};

    unique case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        mem_raddr_o = IDX_W'(in_data_i.read_rank);
        if (in_valid_i) begin
          key_d   = pack_key(in_data_i);
          owner_d = in_data_i.owner_tag;
          res_d   = '0;
          scan_d  = '0;
          if (in_data_i.mode == MODE_INSERT) begin
            if (count_q == CNT_W'(TABLE_DEPTH)) begin
              res_d.status = ST_FULL;
              state_d      = S_DONE;
            end else if (count_q == '0) begin
              state_d = S_WRITE;
            end else begin
              state_d = S_SCAN;
            end
          end else begin
            res_d.rank = in_data_i.read_rank;
            if (CMP_W'(in_data_i.read_rank) < CMP_W'(count_q)) begin
              state_d = S_RDWAIT;
            end else begin
              res_d.status = ST_EMPTY;
              state_d      = S_DONE;
            end
          end
        end
      end
      S_SCAN: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (mem_rdata_i.key <= key_q) begin
          scan_d  = scan_inc;
          state_d = (scan_inc == count_q) ? S_WRITE : S_SCAN;
        end else begin
          ptr_d   = count_q;
          state_d = S_SHRD;
        end
      end
      S_SHRD: begin
        mem_raddr_o = IDX_W'(ptr_dec);
        state_d     = S_SHWR;
      end
      S_SHWR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = IDX_W'(ptr_q);
        mem_wdata_o = mem_rdata_i;
        ptr_d       = ptr_dec;
        state_d     = (ptr_dec == scan_q) ? S_WRITE : S_SHRD;
      end
      S_WRITE: begin
        mem_we_o       = 1'b1;
        id_adv_o       = 1'b1;
        count_d        = count_q + 1'b1;
        res_d.status   = ST_INSERTED;
        res_d.entry_id = next_id_i;
        res_d.rank     = RANK_W'(scan_q);
        state_d        = S_DONE;
      end
      S_RDWAIT: begin
        res_d.status     = ST_READ_OK;
        res_d.entry_id   = mem_rdata_i.id;
        res_d.out_year   = rd_time.year;
        res_d.out_month  = rd_time.month;
        res_d.out_day    = rd_time.day;
        res_d.out_hour   = rd_time.hour;
        res_d.out_minute = rd_time.minute;
        res_d.out_owner  = mem_rdata_i.owner;
        state_d          = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q  <= scan_d;
    ptr_q   <= ptr_d;
    key_q   <= key_d;
    owner_q <= owner_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `TSIT_ASSERT_NORST(a_count_bound, clk_i, !rst_ni || count_q <= CNT_W'(TABLE_DEPTH))
  `TSIT_ASSERT(a_adv_grows_count, clk_i, rst_ni,
    id_adv_o |=> (count_q == $past(count_q) + 1'b1))
  `TSIT_ASSERT(a_shift_above_pos, clk_i, rst_ni,
    (state_q == S_SHRD || state_q == S_SHWR) |-> (ptr_q > scan_q))
  `TSIT_ASSERT(a_write_in_range, clk_i, rst_ni,
    (state_q == S_WRITE) |-> (scan_q <= count_q && count_q < CNT_W'(TABLE_DEPTH)))

endmodule

// ===== design/time_sorted_insert_table_core.sv =====
// Insert: after accept, each entry compared passes scan and compare and each entry
// shifted passes shift read and shift write through the memory read port, then
// write and result. Full-table and empty-rank results follow accept directly; a
// read passes accept, read wait and result. One transaction at a time; the next is
// accepted on return to idle, even while a result waits in the output register.
// Reset clears the entry count, the result valid and the id counter to 0.
module time_sorted_insert_table_core import tsit_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tsit_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output tsit_out_t             out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

  logic [ID_W-1:0]  first_id_q, first_id_d;
  logic [ID_W-1:0]  next_id_q, next_id_d;
  logic             cfg_we;
  logic             id_adv;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_wdata;
  entry_t           mem_rdata;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_FIRST_ID);
  assign prdata = (paddr[2] == REG_FIRST_ID) ? APB_DATA_W'(first_id_q) : '0;

  always_comb begin
    first_id_d = first_id_q;
    next_id_d  = next_id_q;
    if (cfg_we) begin
      first_id_d = pwdata[ID_W-1:0];
      next_id_d  = pwdata[ID_W-1:0];
    end else if (id_adv) begin
      next_id_d = next_id_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_id_q <= '0;
      next_id_q  <= '0;
    end else begin
      first_id_q <= first_id_d;
      next_id_q  <= next_id_d;
    end
  end

  tsit_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .next_id_i  (next_id_q),
    .id_adv_o   (id_adv),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  tsit_mem #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule

// ===== test/time_sorted_insert_table_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench for time_sorted_insert_table_core: directed and random inserts and reads
// with a scoreboard that keeps its own time-ordered table. Depends on tsit_pkg and the core.
module time_sorted_insert_table_core_tb;
  import tsit_pkg::*;

  localparam int unsigned RUN_LIMIT    = 1000000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned LONG_HOLD    = 400;

  class sorted_table_scoreboard;
    time_t           slot_time  [TABLE_DEPTH_DEF];
    logic [7:0]      slot_owner [TABLE_DEPTH_DEF];
    logic [15:0]     slot_id    [TABLE_DEPTH_DEF];
    int unsigned     fill;
    logic [15:0]     id_counter;
    tsit_out_t       pending_results[$];
    int unsigned     fail_count;

    function new();
      fill       = 0;
      id_counter = '0;
      fail_count = 0;
    endfunction

    function void load_first_id(logic [15:0] value);
      id_counter = value;
    endfunction

    function void note_request(tsit_in_t d);
      tsit_out_t r;
      time_t     t;
      int        pos;
      r = '0;
      if (d.mode == MODE_INSERT) begin
        t = {d.year, d.month, d.day, d.hour, d.minute};
        if (fill >= TABLE_DEPTH_DEF) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < fill && slot_time[pos] <= t) pos++;
          for (int i = fill; i > pos; i--) begin
            slot_time[i]  = slot_time[i-1];
            slot_owner[i] = slot_owner[i-1];
            slot_id[i]    = slot_id[i-1];
          end
          slot_time[pos]  = t;
          slot_owner[pos] = d.owner_tag;
          slot_id[pos]    = id_counter;
          fill++;
          r.status   = ST_INSERTED;
          r.entry_id = id_counter;
          r.rank     = pos[3:0];
          id_counter = id_counter + 16'd1;
        end
      end else begin
        r.rank = d.read_rank;
        if (d.read_rank >= fill) begin
          r.status = ST_EMPTY;
        end else begin
          r.status     = ST_READ_OK;
          r.entry_id   = slot_id[d.read_rank];
          r.out_year   = slot_time[d.read_rank].year;
          r.out_month  = slot_time[d.read_rank].month;
          r.out_day    = slot_time[d.read_rank].day;
          r.out_hour   = slot_time[d.read_rank].hour;
          r.out_minute = slot_time[d.read_rank].minute;
          r.out_owner  = slot_owner[d.read_rank];
        end
      end
      pending_results.push_back(r);
    endfunction

    function void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        fail_count++;
      end
    endfunction

    function void check_response(tsit_out_t got);
      tsit_out_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        fail_count++;
        return;
      end
      want = pending_results.pop_front();
      check_field("status", want.status, got.status);
      check_field("entry_id", want.entry_id, got.entry_id);
      check_field("rank", want.rank, got.rank);
      check_field("out_year", want.out_year, got.out_year);
      check_field("out_month", want.out_month, got.out_month);
      check_field("out_day", want.out_day, got.out_day);
      check_field("out_hour", want.out_hour, got.out_hour);
      check_field("out_minute", want.out_minute, got.out_minute);
      check_field("out_owner", want.out_owner, got.out_owner);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  tsit_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  tsit_out_t             out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  sorted_table_scoreboard table_sb = new();
  bit                     long_hold_pending = 1'b0;
  int unsigned            cycle_count = 0;

  time_sorted_insert_table_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic tsit_in_t build_request(mode_e m, int unsigned yr, int unsigned mo,
                                             int unsigned dy, int unsigned hr,
                                             int unsigned mi, int unsigned own,
                                             int unsigned rk);
    tsit_in_t d;
    d.mode      = m;
    d.year      = 14'(yr);
    d.month     = 4'(mo);
    d.day       = 5'(dy);
    d.hour      = 5'(hr);
    d.minute    = 6'(mi);
    d.owner_tag = 8'(own);
    d.read_rank = 4'(rk);
    return d;
  endfunction

  task automatic send_item(tsit_in_t d);
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk_i); while (!in_ready);
    table_sb.note_request(d);
  endtask

  task automatic idle_sender(int unsigned cycles);
    @(negedge clk_i);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (table_sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_first_id(logic [15:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_FIRST_ID, 2'b00};
    pwdata  <= {16'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    table_sb.load_first_id(value);
  endtask

  task automatic send_random(int unsigned count);
    int unsigned sent;
    int unsigned burst;
    tsit_in_t    d;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      for (int k = 0; k < burst && sent < count; k++) begin
        d.mode      = $urandom_range(0, 1) ? MODE_READ : MODE_INSERT;
        d.owner_tag = 8'($urandom);
        d.read_rank = 4'($urandom);
        if ($urandom_range(0, 3) == 0) begin
          d.year   = 14'($urandom);
          d.month  = 4'($urandom);
          d.day    = 5'($urandom);
          d.hour   = 5'($urandom);
          d.minute = 6'($urandom);
        end else begin
          // narrow ranges so that ties and near-ties are common
          d.year   = 14'($urandom_range(2020, 2021));
          d.month  = 4'($urandom_range(1, 2));
          d.day    = 5'($urandom_range(1, 2));
          d.hour   = 5'($urandom_range(0, 1));
          d.minute = 6'($urandom_range(0, 2));
        end
        send_item(d);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 12));
    end
  endtask

  initial begin : receiver
    logic [15:0] rx_cycle;
    int unsigned hold_left;
    rx_cycle  = '0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_cycle[8:7])
          2'd0: out_ready <= 1'b1;
          2'd1: out_ready <= ($urandom_range(0, 3) != 0);
          2'd2: out_ready <= (rx_cycle[2:0] < 3'd5);
          default: out_ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) table_sb.check_response(out_data);
  end

  initial begin : watchdog
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty table, extreme timestamps, id counter from its reset value
    send_item(build_request(MODE_READ, 0, 0, 0, 0, 0, 0, 0));
    send_item(build_request(MODE_READ, 0, 0, 0, 0, 0, 0, 15));
    send_item(build_request(MODE_INSERT, 16383, 15, 31, 31, 63, 255, 15));
    send_item(build_request(MODE_INSERT, 0, 0, 0, 0, 0, 0, 0));
    settle();

    // wrap the id counter; ties and each timestamp field deciding the order
    write_first_id(16'hFFFE);
    send_item(build_request(MODE_INSERT, 0, 0, 0, 0, 0, 1, 0));
    send_item(build_request(MODE_INSERT, 2024, 5, 10, 12, 30, 8'h5A, 0));
    send_item(build_request(MODE_INSERT, 2024, 5, 10, 12, 31, 8'hA5, 0));
    send_item(build_request(MODE_INSERT, 2024, 4, 28, 23, 59, 8'h11, 0));
    send_item(build_request(MODE_INSERT, 2024, 5, 10, 11, 59, 8'h22, 0));
    send_item(build_request(MODE_INSERT, 2024, 5, 9, 23, 59, 8'h44, 0));
    send_item(build_request(MODE_INSERT, 2024, 5, 10, 12, 30, 8'h33, 0));
    send_item(build_request(MODE_INSERT, 2023, 12, 31, 23, 59, 8'h66, 0));
    for (int r = 0; r <= 10; r++) send_item(build_request(MODE_READ, 0, 0, 0, 0, 0, 0, r));
    settle();

    write_first_id(16'hFFFF);
    send_random(600);
    settle();

    // hold the result side off while requests keep coming
    write_first_id(16'($urandom));
    long_hold_pending = 1'b1;
    send_random(600);
    settle();

    write_first_id(16'h0000);
    send_random(600);
    settle();

    if (table_sb.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
